### hdl/miu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse unit package
// Shared width constants, sequencer states and the words exchanged between
// the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package miu_pkg;

    // Working width of the operand and the modulus.
    localparam int unsigned MIU_W = 32;
    // Shift count width: the divisor is never shifted more than MIU_W-1 places.
    localparam int unsigned MIU_KW = (MIU_W > 2) ? $clog2(MIU_W) : 1;
    // Width of the result inverse field.
    localparam int unsigned MIU_OUT_W = 32;
    // Modulus after reset.
    localparam logic [MIU_W-1:0] MIU_MOD_RESET = MIU_W'(2);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_NEXT,
        ST_RED,
        ST_MAP,
        ST_DONE
    } t_state;

    // Operands for the shared unit: x compared with and reduced by y, p added to q.
    typedef struct packed {
        logic [MIU_W:0] x;
        logic [MIU_W:0] y;
        logic [MIU_W:0] p;
        logic [MIU_W:0] q;
    } t_alu_op;

    // Results of the shared unit.
    typedef struct packed {
        logic           ge;
        logic [MIU_W:0] diff;
        logic [MIU_W:0] sum;
    } t_alu_res;

    // One finished result word.
    typedef struct packed {
        logic                 coprime;
        logic [MIU_OUT_W-1:0] inverse;
    } t_result;

endpackage

### hdl/modular_inverse_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse unit
// Tests each operand for coprimality with the configured modulus and returns
// its modular inverse, found by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// One word is worked on at a time; o_ready is high only while the sequencer is
// idle. Each Euclidean step is a shift-and-subtract division on one shared
// compare/subtract/add unit: the divisor is aligned by doubling, subtracted
// once per quotient bit while it is halved again, and then the recurrence is
// advanced, all of which a zero quotient also passes through. The first step
// also reduces the operand by the modulus. Around the divisions a word passes
// through acceptance, coefficient reduction, mapping and hand-over; a modulus
// below two skips the divisions and the reduction. The finished word sits in
// an output register, so the next operand is taken while it waits for
// i_ready; if that register is still full, the sequencer holds its word until
// it drains. The modulus is written through i_cfg_we and i_cfg_data and resets
// to two; it must only change while the block is idle.
// ----------------------------------------------------------------------------
module modular_inverse_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_coprime,
    output logic [31:0] o_inverse
);
    import miu_pkg::*;

    logic [MIU_W-1:0] r_mod;
    logic             r_out_valid;
    t_result          r_out;
    logic             core_idle;
    logic             core_done;
    logic             res_free;
    t_result          core_result;

    // Modulus register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MIU_MOD_RESET;
        end else if (i_cfg_we) begin
            r_mod <= MIU_W'(i_cfg_data);
        end
    end

    // The output register is free when empty or being emptied this cycle.
    assign res_free = !r_out_valid || i_ready;

    miu_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid && core_idle),
        .i_value    (MIU_W'(i_value)),
        .i_mod      (r_mod),
        .i_res_free (res_free),
        .o_idle     (core_idle),
        .o_done     (core_done),
        .o_result   (core_result)
    );

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_done) begin
            r_out <= core_result;
        end
    end

    assign o_ready   = core_idle;
    assign o_valid   = r_out_valid;
    assign o_coprime = r_out.coprime;
    assign o_inverse = r_out.inverse;

endmodule

### hdl/miu_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse shared arithmetic unit
// One compare, one subtractor and one adder, reused by the steps of the
// sequencer: divisor alignment, restoring subtraction, coefficient reduction and the final mapping.
// ----------------------------------------------------------------------------
module miu_alu (
    input  miu_pkg::t_alu_op  i_op,
    output miu_pkg::t_alu_res o_res
);
    import miu_pkg::*;

    // Compare and subtract share the same operands.
    assign o_res.ge   = (i_op.x >= i_op.y);
    assign o_res.diff = i_op.x - i_op.y;

    // Coefficient accumulation.
    assign o_res.sum  = i_op.p + i_op.q;

endmodule

### hdl/miu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse sequencer
// Runs the extended Euclidean algorithm with a shift-and-subtract division
// for each quotient, accumulating the coefficient as the quotient bits appear.
// ----------------------------------------------------------------------------
module miu_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [miu_pkg::MIU_W-1:0] i_value,
    input  logic [miu_pkg::MIU_W-1:0] i_mod,
    input  logic                      i_res_free,
    output logic                      o_idle,
    output logic                      o_done,
    output miu_pkg::t_result          o_result
);
    import miu_pkg::*;

    t_state            r_state, n_state;
    // Remainder pair and coefficient magnitudes of the Euclidean recurrence.
    logic [MIU_W-1:0]  r_r0, n_r0, r_r1, n_r1;
    logic [MIU_W-1:0]  r_u0, n_u0, r_u1, n_u1;
    // Division in progress: running remainder, coefficient accumulator,
    // shifted divisor, shifted coefficient and the shift count.
    logic [MIU_W-1:0]  r_rem, n_rem, r_acc, n_acc;
    logic [MIU_W:0]    r_d, n_d, r_e, n_e;
    logic [MIU_KW-1:0] r_k, n_k;
    logic              r_neg, n_neg;
    logic              r_ok, n_ok;
    logic              r_cop, n_cop;
    logic [MIU_W-1:0]  r_inv, n_inv;

    t_alu_op           alu_op;
    t_alu_res          alu_res;

    miu_alu u_alu (
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_u0  <= n_u0;
        r_u1  <= n_u1;
        r_rem <= n_rem;
        r_acc <= n_acc;
        r_d   <= n_d;
        r_e   <= n_e;
        r_k   <= n_k;
        r_neg <= n_neg;
        r_ok  <= n_ok;
        r_cop <= n_cop;
        r_inv <= n_inv;
    end

    // Next state and datapath control.
    always_comb begin
        n_state = r_state;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_u0    = r_u0;
        n_u1    = r_u1;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_d     = r_d;
        n_e     = r_e;
        n_k     = r_k;
        n_neg   = r_neg;
        n_ok    = r_ok;
        n_cop   = r_cop;
        n_inv   = r_inv;
        alu_op  = '0;
        o_done  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_ok = (i_mod[MIU_W-1:1] != '0);
                    if (i_mod[MIU_W-1:1] != '0) begin
                        // The first division reduces the operand by the modulus;
                        // it is one more Euclidean step with the pair swapped.
                        n_r0    = i_value;
                        n_r1    = i_mod;
                        n_u0    = MIU_W'(1);
                        n_u1    = '0;
                        n_neg   = 1'b1;
                        n_rem   = i_value;
                        n_acc   = MIU_W'(1);
                        n_d     = {1'b0, i_mod};
                        n_e     = '0;
                        n_k     = '0;
                        n_state = ST_ALIGN;
                    end else begin
                        n_state = ST_MAP;
                    end
                end
            end

            ST_ALIGN: begin
                // Double the divisor while it still fits under the remainder.
                alu_op.x = {1'b0, r_rem};
                alu_op.y = {r_d[MIU_W-1:0], 1'b0};
                if (alu_res.ge) begin
                    n_d = {r_d[MIU_W-1:0], 1'b0};
                    n_e = {r_e[MIU_W-1:0], 1'b0};
                    n_k = r_k + MIU_KW'(1);
                end else begin
                    n_state = ST_SUB;
                end
            end

            ST_SUB: begin
                // One quotient bit: subtract the divisor and add the coefficient.
                alu_op.x = {1'b0, r_rem};
                alu_op.y = r_d;
                alu_op.p = {1'b0, r_acc};
                alu_op.q = r_e;
                if (alu_res.ge) begin
                    n_rem = alu_res.diff[MIU_W-1:0];
                    n_acc = alu_res.sum[MIU_W-1:0];
                end
                if (r_k == '0) begin
                    n_state = ST_NEXT;
                end else begin
                    n_d = {1'b0, r_d[MIU_W:1]};
                    n_e = {1'b0, r_e[MIU_W:1]};
                    n_k = r_k - MIU_KW'(1);
                end
            end

            ST_NEXT: begin
                // Advance the recurrence and start the next division if any.
                n_r0  = r_r1;
                n_r1  = r_rem;
                n_u0  = r_u1;
                n_u1  = r_acc;
                n_neg = !r_neg;
                if (r_rem == '0) begin
                    n_state = ST_RED;
                end else begin
                    n_rem   = r_r1;
                    n_acc   = r_u1;
                    n_d     = {1'b0, r_rem};
                    n_e     = {1'b0, r_acc};
                    n_k     = '0;
                    n_state = ST_ALIGN;
                end
            end

            ST_RED: begin
                // The gcd coefficient never exceeds the modulus: one subtraction.
                alu_op.x = {1'b0, r_u0};
                alu_op.y = {1'b0, i_mod};
                if (alu_res.ge) begin
                    n_u0 = alu_res.diff[MIU_W-1:0];
                end
                n_state = ST_MAP;
            end

            ST_MAP: begin
                // Apply the sign of the coefficient to land in 1..modulus-1; zero without an inverse.
                alu_op.x = {1'b0, i_mod};
                alu_op.y = {1'b0, r_u0};
                n_cop    = r_ok && (r_r0 == MIU_W'(1));
                if (!(r_ok && (r_r0 == MIU_W'(1)))) begin
                    n_inv = '0;
                end else if (r_neg) begin
                    n_inv = r_u0;
                end else if (r_u0 == '0) begin
                    n_inv = '0;
                end else begin
                    n_inv = alu_res.diff[MIU_W-1:0];
                end
                n_state = ST_DONE;
            end

            ST_DONE: begin
                // Hand the word over once the output register can take it.
                o_done = i_res_free;
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle           = (r_state == ST_IDLE);
    assign o_result.coprime = r_cop;
    assign o_result.inverse = MIU_OUT_W'(r_inv);

endmodule

### hdl/miu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse port checker
// Watches the ports of the modular inverse unit for busy behaviour and for
// consistency between the coprime flag and the inverse.
// ----------------------------------------------------------------------------
module miu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_coprime,
    input logic [31:0] o_inverse
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_coprime) && $stable(o_inverse)))
        else $error("result word changed while stalled");

    // Taking a word makes the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("block ready straight after taking a word");

    // A value with no inverse reads zero.
    a_zero_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_coprime) |-> (o_inverse == 32'd0))
        else $error("non-zero inverse without the coprime flag");

    // A real inverse is never zero.
    a_nonzero_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_coprime) |-> (o_inverse != 32'd0))
        else $error("zero inverse with the coprime flag set");

endmodule

bind modular_inverse_unit miu_checker u_miu_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse unit testbench
// Words are sent to the unit under a series of modulus settings. A local
// extended Euclidean calculation predicts the coprime flag and the inverse for
// each accepted word, and every returned word is checked against the oldest
// prediction. Both the sender and the receiver idle at random, and one phase
// holds the receiver off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;

    import miu_pkg::*;

    // One prediction, with the operands kept for reporting.
    typedef struct {
        t_result     res;
        logic [31:0] value;
        logic [31:0] modulus;
    } t_pending_inverse;

    localparam int unsigned RANDOM_PHASES  = 12;
    localparam int unsigned PHASE_WORDS    = 160;
    localparam int unsigned PRESSURE_WORDS = 40;
    localparam int unsigned DRAIN_CYCLES   = 250;

    // Modulus kinds used by the random phases.
    typedef enum int {
        MK_SMALL,
        MK_HALF,
        MK_WIDE,
        MK_POW2,
        MK_MAX,
        MK_PRIME,
        MK_ODD_TOP,
        MK_COUNT
    } t_mod_kind;

    // Receiver behaviours.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic        o_coprime;
    logic [31:0] o_inverse;

    t_pending_inverse pending_inverses[$];
    logic [31:0]      modulus_cfg;
    int               error_count;
    int               words_sent;
    int               results_checked;
    int               coprime_seen;
    int               modulus_writes;
    int               burst_left;
    int               hold_left;
    t_rx_mode         rx_mode;
    logic [15:0]      rx_pattern;

    modular_inverse_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_coprime  (o_coprime),
        .o_inverse  (o_inverse)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Expected coprime flag and inverse, by the extended Euclidean algorithm
    // with signed coefficients of the operand.
    function automatic t_result predict_inverse(input logic [31:0] v, input logic [31:0] m);
        t_result res;
        longint  r_prev;
        longint  r_cur;
        longint  s_prev;
        longint  s_cur;
        longint  quot;
        longint  tmp;
        res.coprime = 1'b0;
        res.inverse = '0;
        if (m < 32'd2) begin
            return res;
        end
        r_prev = longint'({32'd0, m});
        r_cur  = longint'({32'd0, v % m});
        if (r_cur == 0) begin
            return res;
        end
        s_prev = 0;
        s_cur  = 1;
        while (r_cur != 0) begin
            quot   = r_prev / r_cur;
            tmp    = r_prev - quot * r_cur;
            r_prev = r_cur;
            r_cur  = tmp;
            tmp    = s_prev - quot * s_cur;
            s_prev = s_cur;
            s_cur  = tmp;
        end
        if (r_prev == 1) begin
            if (s_prev < 0) begin
                s_prev = s_prev + longint'({32'd0, m});
            end
            res.coprime = 1'b1;
            res.inverse = s_prev[31:0];
        end
        return res;
    endfunction

    // Sends one word, idling between bursts, and records its prediction on
    // acceptance. Called and returns on a falling edge.
    task automatic send_value(input logic [31:0] v);
        t_pending_inverse item;
        int               gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid = 1'b1;
        i_value = v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        item.res     = predict_inverse(v, modulus_cfg);
        item.value   = v;
        item.modulus = modulus_cfg;
        pending_inverses.push_back(item);
        words_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Waits until every predicted word has come back and the unit is idle.
    task automatic wait_drained(input int settle);
        while (pending_inverses.size() > 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // Writes the modulus once the unit is idle.
    task automatic write_modulus(input logic [31:0] m);
        wait_drained(8);
        i_cfg_we   = 1'b1;
        i_cfg_data = m;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        modulus_cfg = m;
        modulus_writes++;
    endtask

    // Random operand with a bias towards the edges of the modulus.
    function automatic logic [31:0] pick_value(input logic [31:0] m);
        int unsigned k;
        unique case ($urandom_range(0, 9))
            6: begin
                if (m < 32'd2) begin
                    return 32'd0;
                end
                k = $urandom_range(0, 32'hFFFF_FFFF / m);
                return m * k;
            end
            7: return m - 32'd1;
            8: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            9: return m + $urandom_range(0, 255);
            5: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Modulus of the given kind.
    function automatic logic [31:0] pick_modulus(input t_mod_kind kind);
        logic [31:0] m;
        unique case (kind)
            MK_SMALL:   m = $urandom_range(2, 64);
            MK_HALF:    m = $urandom_range(2, 32'hFFFF);
            MK_POW2:    m = 32'd1 << $urandom_range(1, 31);
            MK_MAX:     m = 32'hFFFF_FFFF;
            MK_PRIME:   m = 32'hFFFF_FFFB;
            MK_ODD_TOP: m = $urandom | 32'h8000_0001;
            default:    m = $urandom;
        endcase
        if (m < 32'd2) begin
            m = 32'd2;
        end
        return m;
    endfunction

    // Receiver: stalls on its own pattern, or holds off when asked to.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                unique case (rx_mode)
                    RX_RANDOM:  i_ready = ($urandom_range(0, 3) != 0);
                    RX_PATTERN: begin
                        i_ready    = rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
                    end
                    default:    i_ready = 1'b1;
                endcase
            end
        end
    end

    // Result checker: compares each returned word with the oldest prediction.
    initial begin
        t_pending_inverse item;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_inverses.size() == 0) begin
                    $display("%0t: unexpected word, coprime %0b inverse 0x%08h",
                             $time, o_coprime, o_inverse);
                    error_count++;
                end else begin
                    item = pending_inverses.pop_front();
                    results_checked++;
                    if (o_coprime) begin
                        coprime_seen++;
                    end
                    if (o_coprime !== item.res.coprime) begin
                        $display("%0t: coprime mismatch, value %h mod %h: exp %0b act %0b",
                                 $time, item.value, item.modulus,
                                 item.res.coprime, o_coprime);
                        error_count++;
                    end
                    if (o_inverse !== item.res.inverse) begin
                        $display("%0t: inverse mismatch, value %h mod %h: exp %h act %h",
                                 $time, item.value, item.modulus,
                                 item.res.inverse, o_inverse);
                        error_count++;
                    end
                end
            end
        end
    end

    // The modulus of two after reset.
    task automatic test_reset_modulus();
        send_value(32'd0);
        send_value(32'd3);
        send_value(32'hFFFF_FFFF);
    endtask

    // Moduli of zero and one have no inverse at all.
    task automatic test_degenerate_modulus();
        write_modulus(32'd0);
        send_value(32'd0);
        send_value(32'd7);
        write_modulus(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1);
    endtask

    // Operand and modulus extremes, and the slowest Euclidean sequence.
    task automatic test_extremes();
        write_modulus(32'hFFFF_FFFF);
        send_value(32'd1);
        send_value(32'd2);
        send_value(32'd3);
        send_value(32'hFFFF_FFFE);
        send_value(32'hFFFF_FFFF);
        write_modulus(32'hFFFF_FFFB);
        send_value(32'd1);
        send_value(32'hFFFF_FFFA);
        send_value(32'hFFFF_FFFB);
        send_value(32'hFFFF_FFFF);
        // Consecutive Fibonacci numbers give the longest quotient chain.
        write_modulus(32'd2971215073);
        send_value(32'd1836311903);
        send_value(32'd1134903170);
    endtask

    // Random operands under a sweep of modulus kinds and receiver modes.
    task automatic test_random_phases();
        t_mod_kind kind;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            kind = t_mod_kind'(p % int'(MK_COUNT));
            write_modulus(pick_modulus(kind));
            rx_mode    = t_rx_mode'(p % 3);
            rx_pattern = 16'h0001 | 16'($urandom);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_value(pick_value(modulus_cfg));
            end
        end
    endtask

    // Long receiver hold-off while words keep coming, so the input stalls.
    task automatic test_output_hold_off();
        write_modulus(32'hFFFF_FFFB);
        rx_mode = RX_ALWAYS;
        @(posedge i_clk);
        hold_left = 600;
        @(negedge i_clk);
        for (int n = 0; n < PRESSURE_WORDS; n++) begin
            send_value($urandom);
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_value      = '0;
        modulus_cfg  = MIU_MOD_RESET;
        error_count  = 0;
        words_sent   = 0;
        results_checked = 0;
        coprime_seen = 0;
        modulus_writes = 0;
        burst_left   = 0;
        hold_left    = 0;
        rx_mode      = RX_ALWAYS;
        rx_pattern   = 16'hB5A3;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_modulus();
        test_degenerate_modulus();
        test_extremes();
        test_random_phases();
        test_output_hold_off();

        wait_drained(DRAIN_CYCLES);
        $display("Sent %0d words under %0d modulus settings, including moduli 0, 1 and 2^32-1.",
                 words_sent, modulus_writes);
        $display("Checked %0d results, %0d of them coprime.", results_checked, coprime_seen);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
